[rtl/rth_pkg.sv]
// Shared widths, payload types and constants for the RGB to HSV pixel converter.
package rth_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;

    // Hue divisor is six times the chroma, so three bits above a channel.
    localparam int DIV_BITS   = CHANNEL_BITS + 3;
    localparam int QUO_BITS   = FRACTION_BITS + 1;
    localparam int DIV_STAGES = FRACTION_BITS + 1;
    localparam int FRONT_STAGES = 2;
    localparam int LATENCY    = FRONT_STAGES + DIV_STAGES;

    localparam logic [QUO_BITS-1:0] SAT_ONE = QUO_BITS'(1) << FRACTION_BITS;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] hue;
        logic [FRACTION_BITS:0]   saturation;
        logic [CHANNEL_BITS-1:0]  value;
    } t_hsv;

    typedef struct packed {
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } t_div_in;

    typedef struct packed {
        logic                    valid;
        logic [CHANNEL_BITS-1:0] value;
        t_div_in                 sat_div;
        t_div_in                 hue_div;
    } t_front_out;

endpackage

[rtl/rth_front.sv]
// Two front stages: channel maximum and minimum, then chroma and divider operands.
module rth_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rth_pkg::t_rgb       i_pixel,
    output rth_pkg::t_front_out o_front
);

    localparam int CB = rth_pkg::CHANNEL_BITS;
    localparam int DB = rth_pkg::DIV_BITS;

    // Stage A registers.
    logic          r_a_vld;
    rth_pkg::t_rgb r_a_rgb;
    logic [CB-1:0] r_a_max;
    logic [CB-1:0] r_a_min;
    logic          r_a_red_max;
    logic          r_a_green_max;

    logic          n_red_max;
    logic          n_green_max;
    logic [CB-1:0] n_max;
    logic [CB-1:0] n_min;
    logic [CB-1:0] w_lo_rg;

    // Stage B.
    rth_pkg::t_front_out r_b;
    rth_pkg::t_front_out n_b;

    logic [CB-1:0] w_chroma;
    logic [DB-1:0] w_c;
    logic [DB-1:0] w_r;
    logic [DB-1:0] w_g;
    logic [DB-1:0] w_b;
    logic [DB-1:0] w_n;

    always_comb begin
        // Ties go to red first, then green.
        n_red_max   = (i_pixel.red >= i_pixel.green) && (i_pixel.red >= i_pixel.blue);
        n_green_max = (i_pixel.green >= i_pixel.blue);
        if (n_red_max) begin
            n_max = i_pixel.red;
        end else if (n_green_max) begin
            n_max = i_pixel.green;
        end else begin
            n_max = i_pixel.blue;
        end
        w_lo_rg = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
        n_min   = (w_lo_rg < i_pixel.blue) ? w_lo_rg : i_pixel.blue;
    end

    always_ff @(posedge i_clk) begin
        r_a_rgb       <= i_pixel;
        r_a_max       <= n_max;
        r_a_min       <= n_min;
        r_a_red_max   <= n_red_max;
        r_a_green_max <= n_green_max;
    end

    always_comb begin
        w_chroma = r_a_max - r_a_min;
        w_c = DB'(w_chroma);
        w_r = DB'(r_a_rgb.red);
        w_g = DB'(r_a_rgb.green);
        w_b = DB'(r_a_rgb.blue);
        // The sums wrap modulo the divider width but always land in 0 .. 6C-1.
        if (r_a_red_max) begin
            if (w_g >= w_b) begin
                w_n = w_g - w_b;
            end else begin
                w_n = (w_c << 2) + (w_c << 1) - (w_b - w_g);
            end
        end else if (r_a_green_max) begin
            w_n = (w_c << 1) + w_b - w_r;
        end else begin
            w_n = (w_c << 2) + w_r - w_g;
        end

        n_b.valid = r_a_vld;
        n_b.value = r_a_max;
        // A zero divisor is replaced by one with a zero numerator, giving a zero quotient.
        n_b.sat_div.num = w_c;
        n_b.sat_div.den = (r_a_max == '0) ? DB'(1) : DB'(r_a_max);
        if (w_chroma == '0) begin
            n_b.hue_div.num = '0;
            n_b.hue_div.den = DB'(1);
        end else begin
            n_b.hue_div.num = w_n;
            n_b.hue_div.den = (w_c << 2) + (w_c << 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_b.value   <= n_b.value;
        r_b.sat_div <= n_b.sat_div;
        r_b.hue_div <= n_b.hue_div;
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else begin
            r_b.valid <= n_b.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
        end
    end

    assign o_front = r_b;

endmodule

[rtl/rth_div.sv]
// Pipelined restoring divider: one quotient bit per stage for a fraction num/den.
module rth_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  rth_pkg::t_div_in               i_div,
    output logic                           o_valid,
    output logic [rth_pkg::QUO_BITS-1:0]   o_quo
);

    localparam int DB = rth_pkg::DIV_BITS;
    localparam int QB = rth_pkg::QUO_BITS;
    localparam int NS = rth_pkg::DIV_STAGES;

    // The numerator never exceeds the divisor, so the first stage yields the integer bit.
    logic [DB-1:0] r_rem [NS-1];
    logic [DB-1:0] r_den [NS-1];
    logic [QB-1:0] r_quo [NS];
    logic [NS-1:0] r_vld;

    logic          n_q0;
    logic [DB-1:0] n_rem0;

    assign n_q0   = (i_div.num >= i_div.den);
    assign n_rem0 = n_q0 ? (i_div.num - i_div.den) : i_div.num;

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_rem0;
        r_den[0] <= i_div.den;
        r_quo[0] <= QB'(n_q0);
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        logic [DB:0] n_sh;
        logic        n_ge;

        assign n_sh = {r_rem[k-1], 1'b0};
        assign n_ge = (n_sh >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            r_quo[k] <= {r_quo[k-1][QB-2:0], n_ge};
        end

        if (k < NS - 1) begin : g_carry
            logic [DB:0] n_diff;

            assign n_diff = n_sh - {1'b0, r_den[k-1]};

            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_ge ? n_diff[DB-1:0] : n_sh[DB-1:0];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_quo[NS-1];

endmodule

[rtl/rgb_to_hsv_pixel.sv]
// Top level of the RGB to HSV pixel converter: front stages, two dividers, value delay.
//
//   Channel   Direction  Signals              Transfer
//   pixel in  input      start, busy, i_pixel start high and busy low at a clock edge
//   hsv out   output     o_done, o_hsv        o_done high for one cycle per result
//
// One pixel may be started in every cycle; busy is held low.
// Each result passes through the front stages and then the divider, which resolves
// one quotient bit per pipeline stage.
// Results leave in start order; the receiver cannot stall, so nothing is held back.
// Reset clears all valid bits at once; results in flight are dropped.
module rgb_to_hsv_pixel (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rth_pkg::t_rgb i_pixel,
    output logic          o_done,
    output rth_pkg::t_hsv o_hsv
);

    localparam int CB = rth_pkg::CHANNEL_BITS;
    localparam int FB = rth_pkg::FRACTION_BITS;
    localparam int NS = rth_pkg::DIV_STAGES;

    rth_pkg::t_front_out w_front;

    logic                         w_hue_vld;
    logic [rth_pkg::QUO_BITS-1:0] w_hue_quo;
    logic                         w_sat_vld;
    logic [rth_pkg::QUO_BITS-1:0] w_sat_quo;

    logic [CB-1:0] r_value [NS];

    assign busy = 1'b0;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_pixel (i_pixel),
        .o_front (w_front)
    );

    rth_div u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front.valid),
        .i_div   (w_front.hue_div),
        .o_valid (w_hue_vld),
        .o_quo   (w_hue_quo)
    );

    rth_div u_sat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front.valid),
        .i_div   (w_front.sat_div),
        .o_valid (w_sat_vld),
        .o_quo   (w_sat_quo)
    );

    // The value waits alongside the dividers so that it meets its own quotients.
    always_ff @(posedge i_clk) begin
        r_value[0] <= w_front.value;
        for (int i = 1; i < NS; i++) begin
            r_value[i] <= r_value[i-1];
        end
    end

    assign o_done = w_hue_vld;

    always_comb begin
        // The hue numerator stays below its divisor, so the integer bit is always clear.
        o_hsv.hue        = w_hue_quo[FB-1:0];
        o_hsv.saturation = w_sat_quo;
        o_hsv.value      = r_value[NS-1];
    end

    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hue_vld == w_sat_vld)
        else $error("hue and saturation dividers out of step");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(rth_pkg::LATENCY) o_done)
        else $error("started pixel did not complete on time");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hsv.saturation <= rth_pkg::SAT_ONE))
        else $error("saturation above one");

    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_hsv.value == '0)) |-> (o_hsv.saturation == '0 && o_hsv.hue == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule
